// File: rtl/core/length_framed_packet_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet receiver
// Each check is sampled on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LFPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lfpr_pkg.sv
// ----------------------------------------------------------------------------
// lfpr_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package lfpr_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // frame layout: start, size, then payload from DATA_POS on
    localparam int SIZE_POS      = 1;
    localparam int DATA_POS      = 2;
    localparam int CONTROL_BYTES = 3;

    localparam logic [7:0] START_BYTE_RST     = 8'd170;
    localparam logic [7:0] END_BYTE_RST       = 8'd85;
    localparam logic [5:0] MAX_FRAME_SIZE_RST = 6'd63;
    localparam logic [4:0] SLOT_COUNT_RST     = 5'd16;

    typedef enum logic [1:0] {
        REG_START_BYTE     = 2'd0,
        REG_END_BYTE       = 2'd1,
        REG_MAX_FRAME_SIZE = 2'd2,
        REG_SLOT_COUNT     = 2'd3
    } lfpr_reg_idx_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [5:0] max_frame_size;
        logic [4:0] slot_count;
    } lfpr_cfg_t;

endpackage

// File: rtl/core/lfpr_regs.sv
// ----------------------------------------------------------------------------
// lfpr_regs
// APB register file holding the framing configuration.
// ----------------------------------------------------------------------------
module lfpr_regs
    import lfpr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output lfpr_cfg_t             cfg
);

    lfpr_cfg_t     cfg_reg;
    lfpr_cfg_t     cfg_next;
    lfpr_reg_idx_t reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = lfpr_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_START_BYTE:     cfg_next.start_byte     = pwdata[7:0];
                REG_END_BYTE:       cfg_next.end_byte       = pwdata[7:0];
                REG_MAX_FRAME_SIZE: cfg_next.max_frame_size = pwdata[5:0];
                REG_SLOT_COUNT:     cfg_next.slot_count     = pwdata[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:     prdata = {24'd0, cfg_reg.start_byte};
            REG_END_BYTE:       prdata = {24'd0, cfg_reg.end_byte};
            REG_MAX_FRAME_SIZE: prdata = {26'd0, cfg_reg.max_frame_size};
            REG_SLOT_COUNT:     prdata = {27'd0, cfg_reg.slot_count};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte     <= START_BYTE_RST;
            cfg_reg.end_byte       <= END_BYTE_RST;
            cfg_reg.max_frame_size <= MAX_FRAME_SIZE_RST;
            cfg_reg.slot_count     <= SLOT_COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/length_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// length_framed_packet_receiver
// Parses start / size / payload / end byte frames and emits the slot id,
// payload length and two command bytes of every good frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_rx_byte
//  m_        out        m_valid / m_ready    m_slot_id, m_payload_len,
//                                            m_left_value, m_right_value
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// One byte per cycle unless a stalled result holds it; a result is registered
// at the edge where the parse stage consumes its end byte from the input register.
// A stalled result holds the parse stage only for an end byte that would
// produce a second result; that byte waits in the input register and
// s_ready follows m_ready until the pending result is taken.
// Synchronous active-low reset clears position, size, valids and config;
// the captured payload bytes are not reset.
// ----------------------------------------------------------------------------
module length_framed_packet_receiver
    import lfpr_pkg::*;
#(
    parameter int BUFFER_BYTES = 64,
    parameter int MAX_SLOTS    = 16,
    parameter int LEFT_OFFSET  = 1,
    parameter int RIGHT_OFFSET = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_slot_id,
    output logic [5:0]            m_payload_len,
    output logic [7:0]            m_left_value,
    output logic [7:0]            m_right_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int POS_W       = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W       = (POS_W + 1 > 6) ? POS_W + 1 : 6;
    localparam int LEFT_IDX    = DATA_POS + LEFT_OFFSET;
    localparam int RIGHT_IDX   = DATA_POS + RIGHT_OFFSET;
    localparam bit LEFT_IN_BUF  = LEFT_IDX < BUFFER_BYTES;
    localparam bit RIGHT_IN_BUF = RIGHT_IDX < BUFFER_BYTES;
    localparam int SLOT_W      = 9;

    lfpr_cfg_t cfg;

    lfpr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [5:0]       size_reg, size_next;
    logic [7:0]       id_byte_reg;
    logic [7:0]       left_byte_reg;
    logic [7:0]       right_byte_reg;

    // result register
    logic       m_valid_reg, m_valid_next;
    logic [3:0] m_slot_id_reg;
    logic [5:0] m_payload_len_reg;
    logic [7:0] m_left_value_reg;
    logic [7:0] m_right_value_reg;

    logic       at_start, at_size, at_end, id_ok, emit, consume, emit_fire;
    logic       store_byte;
    logic [CMP_W-1:0] pos_plus1;
    logic [5:0] payload_len;

    assign at_start  = (pos_reg == POS_W'(0));
    assign at_size   = (pos_reg == POS_W'(SIZE_POS));
    assign pos_plus1 = CMP_W'(pos_reg) + CMP_W'(1);
    assign at_end    = !at_start && !at_size && (in_byte_reg == cfg.end_byte)
                    && (pos_plus1 >= CMP_W'(size_reg));
    assign id_ok     = (SLOT_W'(id_byte_reg) < SLOT_W'(cfg.slot_count))
                    && (SLOT_W'(id_byte_reg) < SLOT_W'(MAX_SLOTS));
    assign emit      = in_valid_reg && at_end && id_ok;
    // only a result-producing byte waits on the output register
    assign consume   = in_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign emit_fire = emit && consume;
    assign s_ready   = !in_valid_reg || consume;
    assign store_byte = consume && !at_start && !at_size && !at_end
                     && (pos_reg < POS_W'(BUFFER_BYTES));
    assign payload_len = (size_reg >= 6'(CONTROL_BYTES))
                       ? size_reg - 6'(CONTROL_BYTES) : 6'd0;

    always_comb begin
        pos_next  = pos_reg;
        size_next = size_reg;
        if (consume) begin
            if (at_start) begin
                if (in_byte_reg == cfg.start_byte) begin
                    pos_next = POS_W'(SIZE_POS);
                end
            end else if (at_size) begin
                if (in_byte_reg > {2'b00, cfg.max_frame_size}) begin
                    pos_next = '0;
                end else begin
                    size_next = in_byte_reg[5:0];
                    pos_next  = POS_W'(DATA_POS);
                end
            end else if (at_end) begin
                pos_next = '0;
            end else if (pos_reg >= POS_W'(BUFFER_BYTES)) begin
                // overrun: drop the frame
                pos_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
            size_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            pos_reg      <= pos_next;
            size_reg     <= size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        // only the three bytes ever read back are kept
        if (store_byte && pos_reg == POS_W'(DATA_POS)) begin
            id_byte_reg <= in_byte_reg;
        end
        if (store_byte && LEFT_IN_BUF && pos_reg == POS_W'(LEFT_IDX)) begin
            left_byte_reg <= in_byte_reg;
        end
        if (store_byte && RIGHT_IN_BUF && pos_reg == POS_W'(RIGHT_IDX)) begin
            right_byte_reg <= in_byte_reg;
        end
        if (emit_fire) begin
            m_slot_id_reg     <= id_byte_reg[3:0];
            m_payload_len_reg <= payload_len;
            m_left_value_reg  <= LEFT_IN_BUF ? left_byte_reg : 8'd0;
            m_right_value_reg <= RIGHT_IN_BUF ? right_byte_reg : 8'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_id     = m_slot_id_reg;
    assign m_payload_len = m_payload_len_reg;
    assign m_left_value  = m_left_value_reg;
    assign m_right_value = m_right_value_reg;

`include "length_framed_packet_receiver_macros.svh"

    `LFPR_ASSERT_SAME(a_no_result_overwrite, emit_fire, !m_valid_reg || m_ready, "result overwritten while stalled")
    `LFPR_ASSERT_NEXT(a_end_resets_pos, consume && at_end, pos_reg == POS_W'(0), "frame position not cleared after end byte")
    `LFPR_ASSERT_NEXT(a_input_held, in_valid_reg && !consume, in_valid_reg && $stable(in_byte_reg), "pending byte lost")
    `LFPR_ASSERT_SAME(a_pos_bounded, 1'b1, pos_reg <= POS_W'(BUFFER_BYTES), "frame position past buffer end")

endmodule
